@@ sv/sorted_bounds_table_top_defines.svh @@
// Assertion macros used by the sorted bounds table checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SORTED_BOUNDS_TABLE_TOP_DEFINES_SVH
`define SORTED_BOUNDS_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted bounds table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted bounds table check failed");

`endif

@@ sv/sbt_pkg.sv @@
// Types and codes for the sorted bounds table.
// Used by the sequencer, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package sbt_pkg;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 4;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic [COUNT_OUT_W-1:0]     entry_count;
        t_status                    status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE,
        S_READ,
        S_FINISH
    } t_state;

endpackage

@@ sv/sbt_mem.sv @@
// Table storage: one write port and one read port with registered read data.
// Depends on sbt_pkg for the entry width.
`timescale 1ns / 1ps

module sbt_mem #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         i_waddr,
    input  logic [sbt_pkg::VALUE_W-1:0]            i_wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         i_raddr,
    output logic [sbt_pkg::VALUE_W-1:0]            o_rdata
);

    logic [sbt_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [sbt_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sbt_ctrl.sv @@
// Sequencer that walks the table memory for insert, remove and read requests
// and keeps the live entry count. Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_ctrl #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_req_valid,
    input  sbt_pkg::t_req                          i_req,
    output logic                                   o_req_stall,
    output logic                                   o_mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]         o_mem_waddr,
    output logic [sbt_pkg::VALUE_W-1:0]            o_mem_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]         o_mem_raddr,
    input  logic [sbt_pkg::VALUE_W-1:0]            i_mem_rdata,
    output logic                                   o_res_valid,
    output sbt_pkg::t_rsp                          o_res,
    input  logic                                   i_res_ready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = AW + 2;
    localparam int IW = (PW > sbt_pkg::INDEX_W) ? PW : sbt_pkg::INDEX_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

    sbt_pkg::t_state                    r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [AW-1:0]                      r_pos, n_pos;
    logic signed [sbt_pkg::VALUE_W-1:0] r_value, n_value;
    logic signed [sbt_pkg::VALUE_W-1:0] r_rdv, n_rdv;
    sbt_pkg::t_status                   r_status, n_status;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic [IW-1:0] idx_w;
    logic [IW-1:0] cnt_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_rdv    <= n_rdv;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_value  = r_value;
        n_rdv    = r_rdv;
        n_status = r_status;

        pos_w = PW'(r_pos);
        cnt_w = PW'(r_count);
        idx_w = IW'(i_req.index);
        cnt_i = IW'(r_count);

        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = r_value;
        o_mem_raddr = '0;

        o_req_stall = (r_state != sbt_pkg::S_IDLE);
        o_res_valid = (r_state == sbt_pkg::S_FINISH);
        o_res.read_value  = r_rdv;
        o_res.entry_count = sbt_pkg::COUNT_OUT_W'(r_count);
        o_res.status      = r_status;

        unique case (r_state)
            sbt_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_value  = i_req.value;
                    n_rdv    = '0;
                    n_status = sbt_pkg::ST_OK;
                    n_state  = sbt_pkg::S_FINISH;
                    unique case (i_req.action)
                        sbt_pkg::ACT_INSERT: begin
                            if (cnt_w >= DEPTH_P) begin
                                n_status = sbt_pkg::ST_FULL;
                            end else begin
                                n_pos = AW'(r_count);
                                if (cnt_w != '0) begin
                                    o_mem_raddr = AW'(cnt_w - PW'(1));
                                end
                                n_state = sbt_pkg::S_INSERT;
                            end
                        end
                        sbt_pkg::ACT_REMOVE: begin
                            if (idx_w >= cnt_i) begin
                                n_status = sbt_pkg::ST_RANGE;
                            end else begin
                                n_pos = idx_w[AW-1:0];
                                if (idx_w + IW'(1) < DEPTH_I) begin
                                    o_mem_raddr = AW'(idx_w + IW'(1));
                                end
                                n_state = sbt_pkg::S_REMOVE;
                            end
                        end
                        sbt_pkg::ACT_READ: begin
                            if (idx_w >= cnt_i) begin
                                n_status = sbt_pkg::ST_RANGE;
                            end else begin
                                o_mem_raddr = idx_w[AW-1:0];
                                n_state     = sbt_pkg::S_READ;
                            end
                        end
                        sbt_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = sbt_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            sbt_pkg::S_INSERT: begin
                o_mem_we = 1'b1;
                if (pos_w != '0 && $signed(i_mem_rdata) > r_value) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = r_pos - AW'(1);
                    if (pos_w >= PW'(2)) begin
                        o_mem_raddr = AW'(pos_w - PW'(2));
                    end
                end else begin
                    o_mem_wdata = r_value;
                    n_count     = r_count + CW'(1);
                    n_state     = sbt_pkg::S_FINISH;
                end
            end
            sbt_pkg::S_REMOVE: begin
                if (pos_w + PW'(1) < cnt_w) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = r_pos + AW'(1);
                    if (pos_w + PW'(2) < DEPTH_P) begin
                        o_mem_raddr = AW'(pos_w + PW'(2));
                    end
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = sbt_pkg::S_FINISH;
                end
            end
            sbt_pkg::S_READ: begin
                n_rdv   = i_mem_rdata;
                n_state = sbt_pkg::S_FINISH;
            end
            sbt_pkg::S_FINISH: begin
                if (i_res_ready) begin
                    n_state = sbt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sbt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sorted_bounds_table_top.sv @@
// Top level of the sorted bounds table: sequencer, table memory, output register.
// Depends on sbt_pkg, sbt_mem and sbt_ctrl.
`timescale 1ns / 1ps

// The block holds up to TABLE_DEPTH signed 32-bit values in ascending order, with
// equal values kept in arrival order, and answers each request with exactly one
// response that carries the entry count after the request. Insert walks down from
// the end of the table one position per cycle, moving larger entries up; remove
// walks up from the index, moving the entries above it down; read fetches the
// entry at the index; clear and rejected requests go straight to the response. The
// table memory, with one read and one write per cycle, sets this pace. Requests are
// taken one at a time. A finished response waits in the output register while the
// next request is already taken.

module sorted_bounds_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sbt_pkg::t_req i_in_req,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output sbt_pkg::t_rsp o_out_rsp,
    input  logic          i_out_stall
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [sbt_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [sbt_pkg::VALUE_W-1:0] mem_rdata;
    logic                        res_valid;
    sbt_pkg::t_rsp               res;
    logic                        res_ready;

    logic          r_out_valid;
    sbt_pkg::t_rsp r_out;

    sbt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_req),
        .o_req_stall (o_in_stall),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    sbt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

@@ sv/sbt_checker.sv @@
// Port-level checks for the sorted bounds table, bound to the top level.
// Depends on sbt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sorted_bounds_table_top_defines.svh"

module sbt_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input sbt_pkg::t_rsp o_out_rsp,
    input logic          i_out_stall
);

    localparam logic [sbt_pkg::COUNT_OUT_W-1:0] FULL_CNT = sbt_pkg::COUNT_OUT_W'(TABLE_DEPTH);

    logic in_accept;
    logic full_rsp;

    assign in_accept = i_in_valid && !o_in_stall;
    assign full_rsp  = o_out_valid && o_out_rsp.status == sbt_pkg::ST_FULL;

    // A full table always reports the full count.
    `SBT_ASSERT_SAME(a_full_count, i_clk, i_rst_n, full_rsp, o_out_rsp.entry_count == FULL_CNT)
    // A rejected request returns a zero read value.
    `SBT_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_out_rsp.status != sbt_pkg::ST_OK, o_out_rsp.read_value == '0)
    // A taken request keeps the block busy in the following cycle.
    `SBT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall)
    // A stalled response holds.
    `SBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_rsp))

endmodule

bind sorted_bounds_table_top sbt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_rsp   (o_out_rsp),
    .i_out_stall (i_out_stall)
);
